// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr must hold at every edge outside reset
`define PCS_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// cons must hold in the cycle after ante
`define PCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PCS_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define PCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, constants and helpers of the percentile contrast stretch core.
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam int MAX_PIXELS_LOG2 = 24;
   localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
   localparam int BIN_COUNT       = 256;
   localparam int BIN_W           = 8;
   localparam int PERM_W          = 10;
   localparam int THR_W           = CNT_W + PERM_W;
   localparam int SUM_W           = CNT_W + BIN_W + PERM_W;
   localparam int NUM_W           = 24;
   localparam int DEN_W           = 16;
   localparam int DIV_STEPS       = NUM_W;
   localparam int DIV_CNT_W       = 5;
   localparam int CSR_IDX_W       = 1;

   localparam logic [CNT_W-1:0]     CNT_MAX     = {CNT_W{1'b1}};
   localparam logic [BIN_W-1:0]     LAST_BIN    = BIN_W'(BIN_COUNT - 1);
   localparam logic [PERM_W-1:0]    LOW_RESET   = PERM_W'(10);
   localparam logic [PERM_W-1:0]    HIGH_RESET  = PERM_W'(990);
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_PERMILLE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_PERMILLE = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       last_pixel;
   } pcs_req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       final_out;
   } pcs_rsp_type;

   typedef struct packed {
      logic accept;
      logic acc_write;
      logic walk_init;
      logic walk;
      logic mul;
      logic div;
      logic load_out;
   } pcs_cmd_type;

   typedef struct packed {
      logic in_op;
      logic in_stretch;
      logic it_last;
      logic walk_done;
      logic div_last;
      logic out_free;
   } pcs_sts_type;

   function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
   endfunction

   function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
   endfunction

   function automatic logic [BIN_W-1:0] lightness(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, max3(r, g, b)} + {1'b0, min3(r, g, b)};
      return s[8:1];
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

endpackage

// ===== rtl/core/pcs_ram.sv =====
// ----------------------------------------------------------------------------
// pcs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcs_ctrl
// Sequencer: accumulate, percentile walk, multiply, divide and output steps.
// ----------------------------------------------------------------------------
module pcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pcs_pkg::pcs_sts_type sts,
   output pcs_pkg::pcs_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_ACC_WR = 7'b0000010,
      ST_PREP   = 7'b0000100,
      ST_WALK   = 7'b0001000,
      ST_MUL    = 7'b0010000,
      ST_DIV    = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!sts.in_op) state_in = ST_ACC_WR;
               else if (sts.in_stretch) state_in = ST_MUL;
               else state_in = ST_OUT;
            end
         end
         ST_ACC_WR: begin
            cmd.acc_write = 1'b1;
            state_in = sts.it_last ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            cmd.walk_init = 1'b1;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_done) state_in = ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (sts.div_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== rtl/core/pcs_datapath.sv =====
// ----------------------------------------------------------------------------
// pcs_datapath
// Histogram RAM, percentile walk, stretch multiply and restoring divider.
// ----------------------------------------------------------------------------
module pcs_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcs_pkg::pcs_cmd_type                  cmd,
   output pcs_pkg::pcs_sts_type                  sts,
   input  pcs_pkg::pcs_req_type                  req_data,
   input  logic                                  csr_valid,
   input  logic [pcs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pcs_pkg::PERM_W-1:0]            csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pcs_pkg::pcs_rsp_type                  rsp_data
);

   localparam int CW = pcs_pkg::CNT_W;
   localparam int BW = pcs_pkg::BIN_W;
   localparam int SW = pcs_pkg::SUM_W;
   localparam int TW = pcs_pkg::THR_W;
   localparam int NW = pcs_pkg::NUM_W;
   localparam int DW = pcs_pkg::DEN_W;

   // config
   logic [pcs_pkg::PERM_W-1:0] low_perm_ff, high_perm_ff;

   // item and bins
   pcs_pkg::pcs_req_type       item_ff;
   logic                       str_ff;
   logic [pcs_pkg::BIN_COUNT-1:0] vld_ff;
   logic [CW-1:0]              total_ff, total_in;
   logic [BW-1:0]              low_bin_ff, high_bin_ff, low_bin_in, high_bin_in;
   logic                       en_ff, en_in;

   // walk
   logic [BW:0]                ra_ff, ra_in;
   logic                       d_v_ff, d_v_in, s_v_ff, s_v_in;
   logic [BW-1:0]              d_bin_ff, d_bin_in, s_bin_ff, s_bin_in;
   logic [SW-1:0]              sum_ff, sum_in;
   logic [TW-1:0]              thr_lo_ff, thr_hi_ff;
   logic                       lo_found_ff, hi_found_ff, lo_found_in, hi_found_in;
   logic [BW-1:0]              lo_ff, hi_ff, lo_in, hi_in;
   logic                       lo_hit, hi_hit;

   // divider
   logic [NW-1:0]              num_ff [3];
   logic [NW-1:0]              num_in [3];
   logic [DW-1:0]              rem_ff [3];
   logic [DW-1:0]              rem_in [3];
   logic [DW-1:0]              den_ff, den_in;
   logic [pcs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // output
   logic                       rsp_valid_ff;
   pcs_pkg::pcs_rsp_type       rsp_ff, rsp_in;

   logic [7:0]                 in_mx, it_mx;
   logic [BW-1:0]              in_l, it_l;
   logic [CW-1:0]              acc_ent, walk_ent;
   logic [SW-1:0]              ent_ext;
   logic [7:0]                 chan [3];
   logic [7:0]                 qclamp [3];
   logic [CW-1:0]              rd_data;
   logic [BW-1:0]              rd_addr;
   logic                       clear_hist;

   assign in_mx   = pcs_pkg::max3(req_data.red_in, req_data.green_in, req_data.blue_in);
   assign in_l    = pcs_pkg::lightness(req_data.red_in, req_data.green_in, req_data.blue_in);
   assign it_mx   = pcs_pkg::max3(item_ff.red_in, item_ff.green_in, item_ff.blue_in);
   assign it_l    = pcs_pkg::lightness(item_ff.red_in, item_ff.green_in, item_ff.blue_in);
   assign chan[0] = item_ff.red_in;
   assign chan[1] = item_ff.green_in;
   assign chan[2] = item_ff.blue_in;

   assign acc_ent  = vld_ff[it_l] ? rd_data : '0;
   assign walk_ent = vld_ff[d_bin_ff] ? rd_data : '0;
   assign ent_ext  = SW'(walk_ent);
   assign rd_addr  = cmd.walk ? ra_ff[BW-1:0] : in_l;
   assign clear_hist = cmd.load_out && item_ff.last_pixel;

   pcs_ram #(
      .WIDTH(CW),
      .DEPTH(pcs_pkg::BIN_COUNT)
   ) u_hist (
      .clock  (clock),
      .wr_en  (cmd.acc_write),
      .wr_addr(it_l),
      .wr_data(pcs_pkg::sat_inc(acc_ent)),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // walk over the cumulative histogram: address, data and compare stages
   always_comb begin
      ra_in       = ra_ff;
      d_v_in      = 1'b0;
      d_bin_in    = d_bin_ff;
      s_v_in      = 1'b0;
      s_bin_in    = s_bin_ff;
      sum_in      = sum_ff;
      lo_hit      = s_v_ff && !lo_found_ff && (sum_ff >= SW'(thr_lo_ff));
      hi_hit      = s_v_ff && !hi_found_ff && (sum_ff >= SW'(thr_hi_ff));
      lo_found_in = lo_found_ff | lo_hit;
      hi_found_in = hi_found_ff | hi_hit;
      lo_in       = lo_hit ? s_bin_ff : lo_ff;
      hi_in       = hi_hit ? s_bin_ff : hi_ff;
      if (cmd.walk_init) begin
         ra_in       = '0;
         sum_in      = '0;
         lo_found_in = 1'b0;
         hi_found_in = 1'b0;
         lo_in       = pcs_pkg::LAST_BIN;
         hi_in       = pcs_pkg::LAST_BIN;
      end else if (cmd.walk) begin
         if (!ra_ff[BW]) begin
            d_v_in   = 1'b1;
            d_bin_in = ra_ff[BW-1:0];
            ra_in    = ra_ff + (BW+1)'(1);
         end
         if (d_v_ff) begin
            // times 1000 as 1024 - 16 - 8
            sum_in   = sum_ff + (ent_ext << 10) - (ent_ext << 4) - (ent_ext << 3);
            s_v_in   = 1'b1;
            s_bin_in = d_bin_ff;
         end
      end
   end

   assign sts.walk_done = cmd.walk && s_v_ff && (s_bin_ff == pcs_pkg::LAST_BIN);

   always_comb begin
      low_bin_in  = low_bin_ff;
      high_bin_in = high_bin_ff;
      en_in       = en_ff;
      if (sts.walk_done) begin
         low_bin_in  = lo_in;
         high_bin_in = hi_in;
         en_in       = hi_in > lo_in;
      end
   end

   always_comb begin
      total_in = total_ff;
      if (clear_hist) total_in = '0;
      else if (cmd.acc_write) total_in = pcs_pkg::sat_inc(total_ff);
   end

   // numerator c*255*(max-lo), denominator (hi-lo)*max, then one quotient bit a cycle
   always_comb begin
      logic [15:0]   c255;
      logic [7:0]    diff;
      logic [DW:0]   r2;
      logic          ge;
      den_in = den_ff;
      cnt_in = cnt_ff;
      for (int c = 0; c < 3; c++) begin
         num_in[c] = num_ff[c];
         rem_in[c] = rem_ff[c];
      end
      c255 = '0;
      diff = it_mx - low_bin_ff;
      r2   = '0;
      ge   = 1'b0;
      if (cmd.mul) begin
         den_in = DW'(high_bin_ff - low_bin_ff) * DW'(it_mx);
         cnt_in = '0;
         for (int c = 0; c < 3; c++) begin
            c255      = {chan[c], 8'h00} - {8'h00, chan[c]};
            num_in[c] = (it_mx > low_bin_ff) ? NW'(c255) * NW'(diff) : '0;
            rem_in[c] = '0;
         end
      end else if (cmd.div) begin
         cnt_in = cnt_ff + pcs_pkg::DIV_CNT_W'(1);
         for (int c = 0; c < 3; c++) begin
            r2        = {rem_ff[c], num_ff[c][NW-1]};
            ge        = r2 >= {1'b0, den_ff};
            rem_in[c] = ge ? DW'(r2 - {1'b0, den_ff}) : r2[DW-1:0];
            num_in[c] = {num_ff[c][NW-2:0], ge};
         end
      end
   end

   assign sts.div_last = (cnt_ff == pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_STEPS - 1));

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         qclamp[c] = (|num_ff[c][NW-1:8]) ? 8'hFF : num_ff[c][7:0];
      end
      rsp_in.red_out   = str_ff ? qclamp[0] : item_ff.red_in;
      rsp_in.green_out = str_ff ? qclamp[1] : item_ff.green_in;
      rsp_in.blue_out  = str_ff ? qclamp[2] : item_ff.blue_in;
      rsp_in.final_out = item_ff.last_pixel;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         low_perm_ff  <= pcs_pkg::LOW_RESET;
         high_perm_ff <= pcs_pkg::HIGH_RESET;
         vld_ff       <= '0;
         total_ff     <= '0;
         low_bin_ff   <= '0;
         high_bin_ff  <= '0;
         en_ff        <= 1'b0;
         d_v_ff       <= 1'b0;
         s_v_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               pcs_pkg::CSR_LOW_PERMILLE:  low_perm_ff  <= csr_wdata;
               pcs_pkg::CSR_HIGH_PERMILLE: high_perm_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (clear_hist) vld_ff <= '0;
         else if (cmd.acc_write) vld_ff[it_l] <= 1'b1;
         total_ff    <= total_in;
         low_bin_ff  <= low_bin_in;
         high_bin_ff <= high_bin_in;
         en_ff       <= en_in;
         d_v_ff      <= d_v_in;
         s_v_ff      <= s_v_in;
         cnt_ff      <= cnt_in;
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_data;
         str_ff  <= en_ff && (in_mx != 8'h00);
      end
      if (cmd.walk_init) begin
         thr_lo_ff <= TW'(low_perm_ff) * TW'(total_ff);
         thr_hi_ff <= TW'(high_perm_ff) * TW'(total_ff);
      end
      ra_ff       <= ra_in;
      d_bin_ff    <= d_bin_in;
      s_bin_ff    <= s_bin_in;
      sum_ff      <= sum_in;
      lo_found_ff <= lo_found_in;
      hi_found_ff <= hi_found_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      den_ff      <= den_in;
      for (int c = 0; c < 3; c++) begin
         num_ff[c] <= num_in[c];
         rem_ff[c] <= rem_in[c];
      end
      if (cmd.load_out) rsp_ff <= rsp_in;
   end

   assign sts.in_op      = req_data.operation;
   assign sts.in_stretch = en_ff && (in_mx != 8'h00);
   assign sts.it_last    = item_ff.last_pixel;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/percentile_contrast_stretch_core.sv =====
// ----------------------------------------------------------------------------
// percentile_contrast_stretch_core
// Two-pass percentile contrast stretch on an RGB pixel stream.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req_    | in  | req_valid/req_stall | pcs_req_type (operation, RGB, last_pixel)
//  rsp_    | out | rsp_valid/rsp_stall | pcs_rsp_type (RGB, final_out)
//  csr_    | in  | csr_valid/csr_ready | csr_index, csr_wdata (permille)
//
// One item at a time. Accumulate item: histogram RAM read on acceptance, then write.
// Last accumulate item adds a walk over all bins, one bin a cycle on the RAM read port.
// Apply item: output step when passed through; multiply, 24-step divider, output when stretched.
// Reset is synchronous; histogram entries are masked by per-bin valid bits cleared at once.
// A stalled result holds in the output register; the next result waits in the output step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module percentile_contrast_stretch_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pcs_pkg::pcs_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pcs_pkg::pcs_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcs_pkg::PERM_W-1:0]    csr_wdata
);

   pcs_pkg::pcs_cmd_type cmd;
   pcs_pkg::pcs_sts_type sts;

   // register writes are always accepted; csr_ready is tied high
   assign csr_ready = 1'b1;

   // sequencer: decides each step from datapath status
   pcs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   // datapath: histogram, bin search, stretch arithmetic, output register
   pcs_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .csr_valid(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // one item in flight: an accepted item blocks the next cycle
   `PCS_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall, "second item taken while busy")
   // never overwrite a result still waiting
   `PCS_ASSERT_ALWAYS(a_load_free, clock, reset, !cmd.load_out || sts.out_free, "result overwritten")
   // accumulate items produce no result
   `PCS_ASSERT_NEXT(a_acc_silent, clock, reset, req_valid && !req_stall && !req_data.operation, !cmd.load_out, "accumulate item gave a result")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the percentile contrast stretch core: queued
// accumulate/apply images under several permille settings and idle patterns,
// each result checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {OP_ACCUMULATE = 1'b0, OP_APPLY = 1'b1} pixel_op_type;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 400;
   localparam int CW = pcs_pkg::CNT_W;
   localparam int PW = pcs_pkg::PERM_W;
   localparam int IW = pcs_pkg::CSR_IDX_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   pcs_pkg::pcs_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pcs_pkg::pcs_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IW-1:0] csr_index = '0;
   logic [PW-1:0] csr_wdata = '0;

   percentile_contrast_stretch_core dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // predictor state
   logic [CW-1:0] hist_m [pcs_pkg::BIN_COUNT];
   logic [CW-1:0] total_m;
   logic [PW-1:0] low_perm_m, high_perm_m;
   logic [7:0] lo_m, hi_m;
   logic stretch_m;

   pcs_pkg::pcs_req_type pixel_q [$];
   pcs_pkg::pcs_rsp_type stretched_q [$];
   int idle_pct = 0, stall_pct = 0;
   bit hold_rsp = 1'b0;
   int mismatches = 0;
   int unsigned cycles = 0;

   function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
      return (v == pcs_pkg::CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [7:0] stretch_ch(input logic [7:0] c, input logic [7:0] mx);
      longint num, den, q;
      num = longint'(c) * 255 * (longint'(mx) - longint'(lo_m));
      den = (longint'(hi_m) - longint'(lo_m)) * longint'(mx);
      if (num <= 0) return 8'd0;
      q = num / den;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   task automatic locate_bins();
      longint sum;
      bit lf, hf;
      lf = 0; hf = 0; sum = 0; lo_m = 8'd255; hi_m = 8'd255;
      for (int i = 0; i < pcs_pkg::BIN_COUNT; i++) begin
         sum += hist_m[i];
         if (!lf && sum * 1000 >= longint'(low_perm_m) * total_m) begin
            lo_m = i[7:0]; lf = 1;
         end
         if (!hf && sum * 1000 >= longint'(high_perm_m) * total_m) begin
            hi_m = i[7:0]; hf = 1;
         end
      end
      stretch_m = hi_m > lo_m;
   endtask

   // advance the predictor on one accepted item
   task automatic predict_pixel(input pcs_pkg::pcs_req_type p);
      logic [7:0] mx, mn;
      logic [8:0] s;
      pcs_pkg::pcs_rsp_type e;
      mx = p.red_in; mn = p.red_in;
      if (p.green_in > mx) mx = p.green_in;
      if (p.blue_in > mx) mx = p.blue_in;
      if (p.green_in < mn) mn = p.green_in;
      if (p.blue_in < mn) mn = p.blue_in;
      if (p.operation == OP_ACCUMULATE) begin
         s = mx + mn;
         hist_m[s[8:1]] = bump(hist_m[s[8:1]]);
         total_m = bump(total_m);
         if (p.last_pixel) locate_bins();
      end else begin
         if (stretch_m && mx != 0) begin
            e.red_out = stretch_ch(p.red_in, mx);
            e.green_out = stretch_ch(p.green_in, mx);
            e.blue_out = stretch_ch(p.blue_in, mx);
         end else begin
            e.red_out = p.red_in; e.green_out = p.green_in; e.blue_out = p.blue_in;
         end
         e.final_out = p.last_pixel;
         stretched_q.push_back(e);
         if (p.last_pixel) begin
            foreach (hist_m[i]) hist_m[i] = '0;
            total_m = '0;
         end
      end
   endtask

   // driver: hold the item while stalled, advance on acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_pixel(req_data);
            void'(pixel_q.pop_front());
         end
         if ((!req_valid || !req_stall) && pixel_q.size() > 0) begin
            if ($urandom_range(99) < idle_pct) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data <= pixel_q[0];
            end
         end else if (req_valid && !req_stall) begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (stretched_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_data);
            end else if (rsp_data !== stretched_q[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %h actual %h", stretched_q[0], rsp_data);
               void'(stretched_q.pop_front());
            end else begin
               void'(stretched_q.pop_front());
            end
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_reg(input logic [IW-1:0] idx, input logic [PW-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == pcs_pkg::CSR_LOW_PERMILLE) low_perm_m = v; else high_perm_m = v;
   endtask

   // wait until nothing is queued or expected, plus the walk latency
   task automatic drain();
      wait (pixel_q.size() == 0 && !req_valid && stretched_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic pcs_pkg::pcs_req_type mk(input logic op, input logic [7:0] r, g, b,
                                               input logic last);
      pcs_pkg::pcs_req_type p;
      p.operation = op; p.red_in = r; p.green_in = g; p.blue_in = b; p.last_pixel = last;
      return p;
   endfunction

   // one image: accumulate pass then apply pass; pixels around a random base, one in ten fully random
   task automatic queue_image(input int n);
      int base, spread;
      base = $urandom_range(255); spread = $urandom_range(255);
      for (int k = 0; k < 2; k++)
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
               pixel_q.push_back(mk(k[0], 8'($urandom), 8'($urandom), 8'($urandom),
                  i == n - 1));
            else
               pixel_q.push_back(mk(k[0], 8'((base + $urandom_range(spread)) % 256),
                  8'((base + $urandom_range(spread)) % 256),
                  8'((base + $urandom_range(spread)) % 256), i == n - 1));
         end
   endtask

   initial begin
      int lows [4];
      int highs [4];
      int idles [4];
      int stalls [4];
      lows = '{0, 10, 500, 1000}; highs = '{1000, 990, 1023, 0};
      idles = '{0, 49, 0, 32}; stalls = '{0, 0, 49, 32};
      foreach (hist_m[i]) hist_m[i] = '0;
      total_m = '0; lo_m = '0; hi_m = '0; stretch_m = 0;
      low_perm_m = pcs_pkg::LOW_RESET; high_perm_m = pcs_pkg::HIGH_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: apply before any histogram, empty pass through, extremes
      pixel_q.push_back(mk(OP_APPLY, 8'd255, 8'd0, 8'd128, 1'b0));
      pixel_q.push_back(mk(OP_APPLY, 8'd0, 8'd0, 8'd0, 1'b1));
      pixel_q.push_back(mk(OP_ACCUMULATE, 8'd0, 8'd0, 8'd0, 1'b0));
      pixel_q.push_back(mk(OP_ACCUMULATE, 8'd255, 8'd255, 8'd255, 1'b0));
      pixel_q.push_back(mk(OP_ACCUMULATE, 8'd64, 8'd128, 8'd200, 1'b0));
      pixel_q.push_back(mk(OP_ACCUMULATE, 8'd10, 8'd20, 8'd30, 1'b1));
      pixel_q.push_back(mk(OP_APPLY, 8'd0, 8'd0, 8'd0, 1'b0));
      pixel_q.push_back(mk(OP_APPLY, 8'd255, 8'd255, 8'd255, 1'b0));
      pixel_q.push_back(mk(OP_APPLY, 8'd1, 8'd0, 8'd0, 1'b0));
      pixel_q.push_back(mk(OP_APPLY, 8'd170, 8'd85, 8'd5, 1'b0));
      pixel_q.push_back(mk(OP_APPLY, 8'd100, 8'd200, 8'd50, 1'b1));
      // single-pixel image: hi<=lo, stretch off
      pixel_q.push_back(mk(OP_ACCUMULATE, 8'd90, 8'd90, 8'd90, 1'b1));
      pixel_q.push_back(mk(OP_APPLY, 8'd90, 8'd40, 8'd10, 1'b1));
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(pcs_pkg::CSR_LOW_PERMILLE, PW'(lows[ph]));
         write_reg(pcs_pkg::CSR_HIGH_PERMILLE, PW'(highs[ph]));
         idle_pct = idles[ph]; stall_pct = stalls[ph];
         for (int im = 0; im < 9; im++) queue_image($urandom_range(4, 40));
         if (ph == 1) begin
            // long receiver hold-off while the sender keeps offering items
            hold_rsp = 1'b1;
            repeat (600) @(posedge clock);
            hold_rsp = 1'b0;
         end
         drain();
      end
      // quartile endpoints on a larger image
      write_reg(pcs_pkg::CSR_LOW_PERMILLE, PW'(250));
      write_reg(pcs_pkg::CSR_HIGH_PERMILLE, PW'(750));
      queue_image(75);
      drain();
      if (mismatches == 0 && stretched_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
